>>> src/ila_pkg.sv
// Shared types and field widths for the indexed list block.
`timescale 1ns / 1ps

package ila_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int INDEX_W  = 5;
    localparam int COUNT_W  = 6;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_DUMP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_DELETE = 2'd2,
        SH_ROTATE = 2'd3
    } shift_t;

    typedef struct packed {
        logic    load_out;
        status_t status;
        logic    dump_entry;
        shift_t  shift;
        logic    idx_clear;
    } ila_cmd_t;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic full;
        logic ins_bad;
        logic del_bad;
        logic dump_last;
    } ila_stat_t;

endpackage

>>> src/ila_in_if.sv
// Input channel: valid/ready plus the operation payload.
`timescale 1ns / 1ps

interface ila_in_if;
    import ila_pkg::*;

    logic                      valid;
    logic                      ready;
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic        [POS_W-1:0]   position;

    modport source (output valid, op, value, position, input ready);
    modport sink   (input valid, op, value, position, output ready);
endinterface

>>> src/ila_out_if.sv
// Output channel: valid/ready plus the result payload.
`timescale 1ns / 1ps

interface ila_out_if;
    import ila_pkg::*;

    logic                      valid;
    logic                      ready;
    status_t                   status;
    logic signed [VALUE_W-1:0] entry_value;
    logic        [INDEX_W-1:0] entry_index;
    logic        [COUNT_W-1:0] entry_count;
    logic                      last;

    modport source (output valid, status, entry_value, entry_index, entry_count, last,
                    input ready);
    modport sink   (input valid, status, entry_value, entry_index, entry_count, last,
                    output ready);
endinterface

>>> src/ila_ctrl.sv
// Controller state machine: decodes beats, sequences dumps, issues datapath commands.
`timescale 1ns / 1ps

module ila_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  ila_pkg::op_t       in_op,
    output logic               in_ready,
    input  ila_pkg::ila_stat_t stat,
    output ila_pkg::ila_cmd_t  cmd
);
    import ila_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.load_out   = 1'b0;
        cmd.status     = ST_OK;
        cmd.dump_entry = 1'b0;
        cmd.shift      = SH_HOLD;
        cmd.idx_clear  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    case (in_op)
                        OP_APPEND:
                        begin
                            cmd.load_out = 1'b1;
                            if (stat.full)
                                cmd.status = ST_FULL;
                            else
                                cmd.shift = SH_INSERT;
                        end
                        OP_INSERT:
                        begin
                            cmd.load_out = 1'b1;
                            if (stat.full)
                                cmd.status = ST_FULL;
                            else if (stat.ins_bad)
                                cmd.status = ST_RANGE;
                            else
                                cmd.shift = SH_INSERT;
                        end
                        OP_DELETE:
                        begin
                            cmd.load_out = 1'b1;
                            if (stat.del_bad)
                                cmd.status = ST_RANGE;
                            else
                                cmd.shift = SH_DELETE;
                        end
                        OP_DUMP:
                        begin
                            if (stat.empty)
                                cmd.load_out = 1'b1;
                            else
                            begin
                                cmd.idx_clear = 1'b1;
                                state_next    = S_DUMP;
                            end
                        end
                        default:
                        begin
                            cmd.load_out = 1'b0;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                // one entry per free output slot; the list rotates so cell 0 is next
                if (stat.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.dump_entry = 1'b1;
                    cmd.shift      = SH_ROTATE;
                    if (stat.dump_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> src/ila_datapath.sv
// Datapath: row of shifting cells, entry count, dump index and output register.
`timescale 1ns / 1ps

module ila_datapath #(
    parameter int CAPACITY = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ila_pkg::op_t                       in_op,
    input  logic signed [ila_pkg::VALUE_W-1:0] in_value,
    input  logic        [ila_pkg::POS_W-1:0]   in_position,
    input  ila_pkg::ila_cmd_t                  cmd,
    output ila_pkg::ila_stat_t                 stat,
    input  logic                               out_ready,
    output logic                               out_valid,
    output ila_pkg::status_t                   out_status,
    output logic signed [ila_pkg::VALUE_W-1:0] out_entry_value,
    output logic        [ila_pkg::INDEX_W-1:0] out_entry_index,
    output logic        [ila_pkg::COUNT_W-1:0] out_entry_count,
    output logic                               out_last
);
    import ila_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int IXW  = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int CXW  = (CW > COUNT_W) ? CW : COUNT_W;

    logic signed [VALUE_W-1:0] cells_reg  [CAPACITY];
    logic signed [VALUE_W-1:0] cells_next [CAPACITY];
    logic signed [VALUE_W-1:0] nbr_lo     [CAPACITY];
    logic signed [VALUE_W-1:0] nbr_hi     [CAPACITY];

    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   count_m1;
    logic [AW-1:0]   idx_reg;
    logic [AW-1:0]   idx_next;
    logic [CMPW-1:0] pos_c;
    logic [CMPW-1:0] cnt_c;
    logic [CMPW-1:0] tgt;
    logic [IXW-1:0]  idx_x;
    logic [CXW-1:0]  cnt_x;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    status_t                   status_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic        [INDEX_W-1:0] index_reg;
    logic        [COUNT_W-1:0] ecount_reg;
    logic                      last_reg;

    // fixed neighbor taps of each cell
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_nbr
            if (g == 0)
            begin : g_lo0
                assign nbr_lo[g] = cells_reg[g];
            end
            else
            begin : g_lo
                assign nbr_lo[g] = cells_reg[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_hi0
                assign nbr_hi[g] = cells_reg[g];
            end
            else
            begin : g_hi
                assign nbr_hi[g] = cells_reg[g+1];
            end
        end
    endgenerate

    assign pos_c    = CMPW'(in_position);
    assign cnt_c    = CMPW'(count_reg);
    assign tgt      = (in_op == OP_APPEND) ? cnt_c : pos_c;
    assign count_m1 = count_reg - CW'(1);

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CW'(CAPACITY));
    assign stat.ins_bad   = (pos_c > cnt_c);
    assign stat.del_bad   = (pos_c >= cnt_c);
    assign stat.dump_last = (CW'(idx_reg) == count_m1);

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cells_next[i] = cells_reg[i];
            case (cmd.shift)
                SH_INSERT:
                begin
                    if (CMPW'(i) > tgt)
                        cells_next[i] = nbr_lo[i];
                    else if (CMPW'(i) == tgt)
                        cells_next[i] = in_value;
                end
                SH_DELETE:
                begin
                    if (CMPW'(i) >= tgt)
                        cells_next[i] = nbr_hi[i];
                end
                SH_ROTATE:
                begin
                    // rotate the held part; cells above it shift down, and count beats restore the order
                    if (CW'(i) == count_m1)
                        cells_next[i] = cells_reg[0];
                    else
                        cells_next[i] = nbr_hi[i];
                end
                default:
                begin
                    cells_next[i] = cells_reg[i];
                end
            endcase
        end
    end

    always_comb
    begin
        case (cmd.shift)
            SH_INSERT: count_next = count_reg + CW'(1);
            SH_DELETE: count_next = count_m1;
            default:   count_next = count_reg;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clear)
            idx_next = '0;
        else if (cmd.shift == SH_ROTATE)
            idx_next = idx_reg + AW'(1);
    end

    assign idx_x = IXW'(idx_reg);
    assign cnt_x = CXW'(count_next);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
            cells_reg[i] <= cells_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg <= cmd.status;
            ecount_reg <= cnt_x[COUNT_W-1:0];
            if (cmd.dump_entry)
            begin
                value_reg <= cells_reg[0];
                index_reg <= idx_x[INDEX_W-1:0];
                last_reg  <= stat.dump_last;
            end
            else
            begin
                value_reg <= '0;
                index_reg <= '0;
                last_reg  <= 1'b1;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = status_reg;
    assign out_entry_value = value_reg;
    assign out_entry_index = index_reg;
    assign out_entry_count = ecount_reg;
    assign out_last        = last_reg;

endmodule

>>> src/indexed_list_insert_delete.sv
// Indexed list top level: insert/delete/append/dump over a valid-ready channel pair.
`timescale 1ns / 1ps

// Usage:
//   item   : sink channel; op (append, insert, delete, dump), value, position.
//   result : source channel; status, entry_value, entry_index, entry_count, last.
//   Append, insert and delete produce one result beat, registered, visible the
//   cycle after the item beat; the store and count update on that same edge.
//   A dump of N entries produces N beats from the dump state, one per cycle
//   while the receiver keeps up; an empty list dumps a single beat with last
//   set. Throughput: one item per cycle for append/insert/delete while the
//   receiver keeps up; a dump holds off new items through its last beat.
//   The whole row of cells shifts at once; a dump rotates it one cell per beat.
//   Bad index or full list gives a status code and leaves the list untouched.
//   Backpressure: the result register holds its beat while ready is low, and
//   item.ready drops until the result slot frees.
//   Reset (rst_n low, asynchronous) empties the list and drops result.valid;
//   cell contents are not cleared.
module indexed_list_insert_delete #(
    parameter int CAPACITY = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ila_in_if.sink    item,
    ila_out_if.source result
);
    import ila_pkg::*;

    ila_cmd_t  cmd;
    ila_stat_t stat;

    ila_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_op    (item.op),
        .in_ready (item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ila_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_op           (item.op),
        .in_value        (item.value),
        .in_position     (item.position),
        .cmd             (cmd),
        .stat            (stat),
        .out_ready       (result.ready),
        .out_valid       (result.valid),
        .out_status      (result.status),
        .out_entry_value (result.entry_value),
        .out_entry_index (result.entry_index),
        .out_entry_count (result.entry_count),
        .out_last        (result.last)
    );

    // a result is only loaded into a free slot
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result register overwritten while occupied");

    // a full list never takes another entry
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        stat.full |-> cmd.shift != SH_INSERT)
        else $error("insert issued on a full list");

    // single-result items show their beat on the next cycle
    a_single_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.op != OP_DUMP) |=> (result.valid && result.last))
        else $error("missing result after item beat");

    // mid-dump beats block new items
    a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.last) |-> !item.ready)
        else $error("item accepted during dump");

endmodule

>>> sim/indexed_list_insert_delete_tb.sv
// Testbench for the indexed list block: directed and random ops checked against a list model.
`timescale 1ns / 1ps

module indexed_list_insert_delete_tb;
    import ila_pkg::*;

    localparam int LIST_CAP     = 32;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYC    = 11;
    localparam int DRAIN_CYC    = 20;
    localparam int STALL_CYC    = 200;
    localparam int RANDOM_ITEMS = 240;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        status_t                   status;
        logic signed [VALUE_W-1:0] entry_value;
        logic        [INDEX_W-1:0] entry_index;
        logic        [COUNT_W-1:0] entry_count;
        logic                      last;
    } list_beat_t;

    logic clk;
    logic rst_n;

    ila_in_if  item_ch ();
    ila_out_if result_ch ();

    indexed_list_insert_delete #(
        .CAPACITY(LIST_CAP)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .result(result_ch)
    );

    // list model
    logic signed [VALUE_W-1:0] list_cells [LIST_CAP];
    int                        list_len;
    list_beat_t                beat_q [$];
    list_beat_t                want_beat;

    int err_count;
    int cycle_cnt = 0;
    bit tx_idle_on;
    bit rx_idle_on;
    int rx_stall_req;
    int rx_stall_left;

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt, beat_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("ERROR %0t: %s expected %0h got %0h", $time, what, want, got);
        err_count++;
    endtask

    function automatic list_beat_t make_beat(status_t st, logic signed [VALUE_W-1:0] v,
                                             int idx, logic lst);
        list_beat_t b;
        b.status      = st;
        b.entry_value = v;
        b.entry_index = idx[INDEX_W-1:0];
        b.entry_count = list_len[COUNT_W-1:0];
        b.last        = lst;
        return b;
    endfunction

    // Apply one accepted item to the model and queue the beats it should produce.
    task automatic predict_list_op(op_t op, logic signed [VALUE_W-1:0] v,
                                   logic [POS_W-1:0] pos);
        int i;
        case (op)
            OP_DUMP:
            begin
                if (list_len == 0)
                    beat_q.push_back(make_beat(ST_OK, '0, 0, 1'b1));
                else
                    for (i = 0; i < list_len; i++)
                        beat_q.push_back(make_beat(ST_OK, list_cells[i], i, i == list_len - 1));
            end
            OP_APPEND:
            begin
                if (list_len >= LIST_CAP)
                    beat_q.push_back(make_beat(ST_FULL, '0, 0, 1'b1));
                else
                begin
                    list_cells[list_len] = v;
                    list_len++;
                    beat_q.push_back(make_beat(ST_OK, '0, 0, 1'b1));
                end
            end
            OP_INSERT:
            begin
                // full wins over a bad index
                if (list_len >= LIST_CAP)
                    beat_q.push_back(make_beat(ST_FULL, '0, 0, 1'b1));
                else if (int'(pos) > list_len)
                    beat_q.push_back(make_beat(ST_RANGE, '0, 0, 1'b1));
                else
                begin
                    for (i = list_len; i > int'(pos); i--)
                        list_cells[i] = list_cells[i - 1];
                    list_cells[pos] = v;
                    list_len++;
                    beat_q.push_back(make_beat(ST_OK, '0, 0, 1'b1));
                end
            end
            default:
            begin
                if (int'(pos) >= list_len)
                    beat_q.push_back(make_beat(ST_RANGE, '0, 0, 1'b1));
                else
                begin
                    for (i = int'(pos); i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i + 1];
                    list_len--;
                    beat_q.push_back(make_beat(ST_OK, '0, 0, 1'b1));
                end
            end
        endcase
    endtask

    // Offer one item from the falling edge; returns at the rising edge that takes it.
    task automatic send_item(op_t op, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] pos);
        bit taken;
        taken = 1'b0;
        @(negedge clk);
        while (tx_idle_on && $urandom_range(0, 99) < 33)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.op       = op;
        item_ch.value    = v;
        item_ch.position = pos;
        item_ch.valid    = 1'b1;
        while (!taken)
        begin
            @(posedge clk);
            if (item_ch.ready)
            begin
                taken = 1'b1;
                predict_list_op(op, v, pos);
            end
            else
                @(negedge clk);
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] rand_value();
        logic signed [VALUE_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7fff_ffff;
                2:       v = '0;
                default: v = -32'sd1;
            endcase
        end
        return v;
    endfunction

    // receiver: random ready, or a counted hold-off on request
    always @(negedge clk)
    begin
        if (rx_stall_req > 0)
        begin
            rx_stall_left = rx_stall_req;
            rx_stall_req  = 0;
        end
        if (!rst_n)
            result_ch.ready = 1'b0;
        else if (rx_stall_left > 0)
        begin
            result_ch.ready = 1'b0;
            rx_stall_left--;
        end
        else
            result_ch.ready = !(rx_idle_on && $urandom_range(0, 99) < 33);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (beat_q.size() == 0)
                report_mismatch("beat with nothing pending, value", '0, result_ch.entry_value);
            else
            begin
                want_beat = beat_q.pop_front();
                if (result_ch.status !== want_beat.status)
                    report_mismatch("status", want_beat.status, result_ch.status);
                if (result_ch.entry_value !== want_beat.entry_value)
                    report_mismatch("entry_value", want_beat.entry_value, result_ch.entry_value);
                if (result_ch.entry_index !== want_beat.entry_index)
                    report_mismatch("entry_index", want_beat.entry_index, result_ch.entry_index);
                if (result_ch.entry_count !== want_beat.entry_count)
                    report_mismatch("entry_count", want_beat.entry_count, result_ch.entry_count);
                if (result_ch.last !== want_beat.last)
                    report_mismatch("last", want_beat.last, result_ch.last);
            end
        end
    end

    // empty list, value extremes, insert/delete at head, middle and tail, bad indexes
    task automatic test_edit_cases();
        send_item(OP_DUMP,   '0, 5'd0);
        send_item(OP_DELETE, '0, 5'd0);
        send_item(OP_DELETE, '0, 5'd31);
        send_item(OP_INSERT, 32'sh1234_5678, 5'd1);
        send_item(OP_INSERT, 32'sh7fff_ffff, 5'd0);
        send_item(OP_INSERT, 32'sh0bad_0bad, 5'd2);
        send_item(OP_APPEND, 32'sh8000_0000, 5'd31);
        send_item(OP_APPEND, '0, 5'd0);
        send_item(OP_APPEND, -32'sd1, 5'd17);
        send_item(OP_INSERT, 32'sh5555_5555, 5'd1);
        send_item(OP_INSERT, 32'shaaaa_aaaa, 5'd5);
        send_item(OP_DUMP,   '0, 5'd0);
        send_item(OP_DELETE, '0, 5'd5);
        send_item(OP_DELETE, '0, 5'd0);
        send_item(OP_DELETE, '0, 5'd1);
        send_item(OP_DELETE, '0, 5'd5);
        send_item(OP_DUMP,   '0, 5'd31);
    endtask

    // fill to capacity, hit the full cases, dump a full list, edit at the top index
    task automatic test_full_list();
        while (list_len < LIST_CAP)
            send_item(OP_APPEND, rand_value(), 5'($urandom_range(0, 31)));
        send_item(OP_APPEND, 32'sh0f0f_0f0f, 5'd0);
        send_item(OP_INSERT, 32'sh0f0f_0f0f, 5'd0);
        send_item(OP_INSERT, 32'sh0f0f_0f0f, 5'd31);
        send_item(OP_DUMP,   '0, 5'd0);
        send_item(OP_DELETE, '0, 5'd31);
        send_item(OP_INSERT, 32'sh7fff_ffff, 5'd31);
        send_item(OP_DELETE, '0, 5'd0);
        send_item(OP_DUMP,   '0, 5'd0);
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_backpressure();
        int n;
        tx_idle_on   = 1'b0;
        rx_stall_req = STALL_CYC;
        for (n = 0; n < 12; n++)
        begin
            case (n % 4)
                0:       send_item(OP_DUMP, '0, 5'd0);
                1:       send_item(OP_DELETE, '0, 5'($urandom_range(0, 31)));
                2:       send_item(OP_APPEND, rand_value(), 5'd0);
                default: send_item(OP_INSERT, rand_value(), 5'($urandom_range(0, 8)));
            endcase
        end
        tx_idle_on = 1'b1;
    endtask

    // mostly legal positions; the fill level sweeps between empty and full
    task automatic test_random_ops();
        int               n;
        int               r;
        int               hi;
        bit               grow;
        op_t              op;
        logic [POS_W-1:0] pos;
        grow = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 100)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (n == 160)
            begin
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end
            if (list_len == LIST_CAP && $urandom_range(0, 3) == 0)
                grow = 1'b0;
            if (list_len == 0)
                grow = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 8)
                op = OP_DUMP;
            else if (r < (grow ? 75 : 40))
                op = r[0] ? OP_INSERT : OP_APPEND;
            else
                op = OP_DELETE;
            hi = (op == OP_DELETE) ? list_len - 1 : list_len;
            if (hi < 0)
                hi = 0;
            if (hi > 31)
                hi = 31;
            if ((op == OP_INSERT || op == OP_DELETE) && $urandom_range(0, 99) < 85)
                pos = 5'($urandom_range(0, hi));
            else
                pos = 5'($urandom_range(0, 31));
            send_item(op, rand_value(), pos);
        end
    endtask

    initial
    begin
        item_ch.valid    = 1'b0;
        item_ch.op       = OP_APPEND;
        item_ch.value    = '0;
        item_ch.position = '0;
        result_ch.ready  = 1'b0;
        rst_n            = 1'b0;
        err_count        = 0;
        list_len         = 0;
        tx_idle_on       = 1'b1;
        rx_idle_on       = 1'b1;
        rx_stall_req     = 0;
        rx_stall_left    = 0;
        repeat (RESET_CYC) @(negedge clk);
        rst_n = 1'b1;

        test_edit_cases();
        test_full_list();
        test_backpressure();
        test_random_ops();

        @(negedge clk);
        item_ch.valid = 1'b0;
        while (beat_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
